// ----- rtl/pres7_pkg.sv -----
// Shared types and constants of the seven-point residual block.
package pres7_pkg;

  localparam int WORD_W    = 32;
  localparam int LAP_W     = 38;
  localparam int MAG_W     = LAP_W - 1;
  localparam int HALF_W    = 16;
  localparam int GS_W      = 7;
  localparam int INV_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int MIN_EDGE  = 3;

  // Result queue: depth and the widths of its pointers and fill count
  localparam int OQ_DEPTH = 16;
  localparam int OQ_AW    = 4;
  localparam int OQ_CW    = 5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_DX_SQ = 1'b1;

  localparam logic [GS_W-1:0]  GS_RESET  = 7'd64;
  localparam logic [INV_W-1:0] INV_RESET = 32'h0001_0000;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t WORD_MAX = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  // Per-item control carried down the plane pipeline
  typedef struct packed {
    logic emit;   // item releases a result
    logic inner;  // result point is interior
    logic last;   // result point is the final grid point
  } tag_t;

  // Centre value and its six neighbours (i plane, j row, k column)
  typedef struct packed {
    word_t c;
    word_t im;
    word_t ip;
    word_t jm;
    word_t jp;
    word_t km;
    word_t kp;
  } nbr_t;

  typedef struct packed {
    word_t residual;
    logic  last;
  } res_t;

endpackage

// ----- rtl/pres7_delay.sv -----
// Run-time length delay line on a single-port read-first memory.
module pres7_delay #(
  parameter int DEPTH = 4032
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     clr,
  input  logic                     en,
  input  logic [$clog2(DEPTH)-1:0] len_m1,
  input  pres7_pkg::word_t         din,
  output pres7_pkg::word_t         dout
);
  import pres7_pkg::*;

  localparam int AW = $clog2(DEPTH);

  word_t          mem [DEPTH];
  word_t          dout_r;
  logic [AW-1:0]  ptr_r;
  logic [AW-1:0]  ptr_nxt;

  // Wrap the pointer at the programmed length
  always_comb begin
    ptr_nxt = (ptr_r == len_m1) ? '0 : ptr_r + AW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      ptr_r <= '0;
    end else if (en) begin
      ptr_r <= ptr_nxt;
    end
  end

  // Read the word written one full lap ago, then overwrite it
  always_ff @(posedge clk) begin
    if (en) begin
      dout_r      <= mem[ptr_r];
      mem[ptr_r]  <= din;
    end
  end

  assign dout = dout_r;

endmodule

// ----- rtl/pres7_arith.sv -----
// Residual arithmetic: stencil sum, scaling by 1/dx^2 with rounding, saturation.
module pres7_arith (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_vld,
  input  pres7_pkg::nbr_t               nbr,
  input  pres7_pkg::word_t              f_val,
  input  logic                          inner,
  input  logic                          last,
  input  logic [pres7_pkg::INV_W-1:0]   inv,
  output logic                          out_vld,
  output pres7_pkg::res_t               out_res
);
  import pres7_pkg::*;

  localparam int PW = MAG_W + HALF_W;
  localparam logic [PW:0]   ROUND_HALF = (PW+1)'(1) << (HALF_W - 1);
  localparam logic [PW-1:0] SAT_LIM    = PW'(1) << (WORD_W - 1);

  typedef logic signed [LAP_W-1:0] lap_t;

  typedef struct packed {
    word_t f;
    logic  inner;
    logic  last;
  } side_t;

  function automatic lap_t sx(input word_t v);
    sx = {{(LAP_W-WORD_W){v[WORD_W-1]}}, v};
  endfunction

  logic [7:1]        v_r;
  side_t             side1_r, side2_r, side3_r, side4_r, side5_r, side6_r;
  lap_t              sa1_r, sb1_r, u61_r;
  lap_t              lap2_r;
  logic              neg3_r, neg4_r, neg5_r;
  logic [MAG_W-1:0]  mag3_r;
  logic [PW-1:0]     ph4_r, pl4_r;
  logic [PW-1:0]     q5_r;
  word_t             sc6_r;
  res_t              res7_r;

  lap_t              u_ext;
  lap_t              mag_full;
  logic [PW:0]       rnd;
  logic [WORD_W:0]   diff;
  word_t             diff_sat;

  // Stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[6:1], in_vld};
    end
  end

  always_comb begin
    u_ext    = sx(nbr.c);
    mag_full = lap2_r[LAP_W-1] ? -lap2_r : lap2_r;
    rnd      = {1'b0, pl4_r} + ROUND_HALF;
    diff     = {side6_r.f[WORD_W-1], side6_r.f} - {sc6_r[WORD_W-1], sc6_r};
    if (diff[WORD_W] != diff[WORD_W-1]) begin
      diff_sat = diff[WORD_W] ? WORD_MIN : WORD_MAX;
    end else begin
      diff_sat = word_t'(diff[WORD_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    // Partial sums of the neighbours and six times the centre
    sa1_r   <= sx(nbr.im) + sx(nbr.ip) + sx(nbr.jm);
    sb1_r   <= sx(nbr.jp) + sx(nbr.km) + sx(nbr.kp);
    u61_r   <= (u_ext <<< 2) + (u_ext <<< 1);
    side1_r <= '{f: f_val, inner: inner, last: last};

    // Laplacian numerator
    lap2_r  <= sa1_r + sb1_r - u61_r;
    side2_r <= side1_r;

    // Sign and magnitude
    neg3_r  <= lap2_r[LAP_W-1];
    mag3_r  <= mag_full[MAG_W-1:0];
    side3_r <= side2_r;

    // Two half-width partial products against 1/dx^2
    ph4_r   <= PW'(mag3_r) * PW'(inv[INV_W-1:HALF_W]);
    pl4_r   <= PW'(mag3_r) * PW'(inv[HALF_W-1:0]);
    neg4_r  <= neg3_r;
    side4_r <= side3_r;

    // Drop sixteen fraction bits, rounding halves away from zero
    q5_r    <= ph4_r + PW'(rnd >> HALF_W);
    neg5_r  <= neg4_r;
    side5_r <= side4_r;

    // Restore sign and saturate the scaled term
    if (q5_r >= SAT_LIM) begin
      sc6_r <= neg5_r ? WORD_MIN : WORD_MAX;
    end else begin
      sc6_r <= neg5_r ? -$signed(q5_r[WORD_W-1:0]) : $signed(q5_r[WORD_W-1:0]);
    end
    side6_r <= side5_r;

    // Residual, zero on the boundary
    res7_r.residual <= side6_r.inner ? diff_sat : '0;
    res7_r.last     <= side6_r.last;
  end

  assign out_vld = v_r[7];
  assign out_res = res7_r;

endmodule

// ----- rtl/pres7_fifo.sv -----
// Result queue that parts the pipeline from the output channel.
module pres7_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  pres7_pkg::res_t  wr_data,
  output logic             rd_vld,
  input  logic             rd_rdy,
  output pres7_pkg::res_t  rd_data
);
  import pres7_pkg::*;

  res_t              mem [OQ_DEPTH];
  logic [OQ_AW-1:0]  wp_r, rp_r;
  logic [OQ_CW-1:0]  cnt_r;
  logic [OQ_CW-1:0]  cnt_nxt;
  logic              rd;

  assign rd_vld  = (cnt_r != '0);
  assign rd      = rd_vld && rd_rdy;
  assign rd_data = mem[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en) cnt_nxt = cnt_nxt + OQ_CW'(1);
    if (rd)    cnt_nxt = cnt_nxt - OQ_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + OQ_AW'(1);
      if (rd)    rp_r <= rp_r + OQ_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_data;
    end
  end

endmodule

// ----- rtl/poisson_residual_7pt_3d_top.sv -----
// Top level of the streamed seven-point 3-D Laplacian residual block.
//
// Input beats carry one grid point (u, f) in raster order, plane outer, column
// inner; in_tuser marks a pad beat whose u and f count as zero. Each beat from
// point N*N onwards releases one output beat with the residual of the point
// N*N places earlier; out_tlast flags the final point of the N^3 grid, after
// which the next input beat is point 0 of a new grid. Boundary points give 0.
// Throughput is one beat per cycle while in_tready is high. The edge that takes
// a beat loads the first of four stages around the plane and row delay lines
// (single-port memories of up to MAX_EDGE^2 words); seven arithmetic stages
// follow and the result queue adds one more register before out_tvalid.
// Input is admitted on a credit of 16 beats in flight or queued, so when the
// receiver stalls results pile up in the queue and in_tready falls once 16 are
// outstanding. Configuration is taken through cfg_we/cfg_index/cfg_wdata;
// write it only while idle, as the block itself does not enforce this.
// After reset, and after a grid_size write, in_tready stays low while the
// derived grid lengths settle; a grid_size write restarts the grid.
module poisson_residual_7pt_3d_top #(
  parameter int MAX_EDGE = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input: tdata = u_value [31:0], f_value [63:32]; tuser = pad
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [2*pres7_pkg::WORD_W-1:0]      in_tdata,
  input  logic                                in_tuser,
  // Output: tdata = residual [31:0]; tlast = is_last
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [pres7_pkg::WORD_W-1:0]        out_tdata,
  output logic                                out_tlast,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [pres7_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pres7_pkg::INV_W-1:0]         cfg_wdata
);
  import pres7_pkg::*;

  localparam int NW       = $clog2(MAX_EDGE + 1);
  localparam int NNW      = $clog2(MAX_EDGE * MAX_EDGE + 1);
  localparam int CW       = (NW > GS_W) ? NW : GS_W;
  localparam int PL_DEPTH = MAX_EDGE * (MAX_EDGE - 1);
  localparam int PL_AW    = $clog2(PL_DEPTH);
  localparam int RW_DEPTH = MAX_EDGE - 1;
  localparam int RW_AW    = $clog2(RW_DEPTH);
  localparam int FD_DEPTH = MAX_EDGE * MAX_EDGE;
  localparam int FD_AW    = $clog2(FD_DEPTH);
  localparam logic [1:0] HOLD_INIT = 2'd3;

  // Configuration and derived lengths
  logic [GS_W-1:0]   grid_size_r;
  logic [INV_W-1:0]  inv_r;
  logic [1:0]        hold_r;
  logic              grid_wr;
  logic [CW-1:0]     gs_ext;
  logic [NW-1:0]     n_nxt;
  logic [NW-1:0]     n_r, nm1_r, nm2_r;
  logic [NNW-1:0]    nn_r, nnm1_r;
  logic [PL_AW-1:0]  pl_m1_r;
  logic [RW_AW-1:0]  rw_m1_r;
  logic [FD_AW-1:0]  fd_m1_r;

  // Point sequencer
  logic              acc;
  logic              emit_r;
  logic [NNW-1:0]    fill_r;
  logic [NW-1:0]     i_r, j_r, k_r;
  logic              i_top, j_top, k_top;
  logic              seq_last;
  logic              seq_inner;
  tag_t              in_tag;
  word_t             x_in, f_in;

  // Plane pipeline
  logic              v1_r, v2_r, v3_r, v4_r;
  tag_t              tag1_r, tag2_r, tag3_r, tag4_r;
  word_t             x1_r, x2_r, x3_r, x4_r;
  word_t             a2_r, a3_r, a4_r;
  word_t             fd2_r, fd3_r, fd4_r;
  word_t             b3_r, b4_r;
  word_t             cen3_r, cen4_r, west3_r, west4_r;
  word_t             c4_r;
  word_t             p1_r, p2_r;
  word_t             a_q, b_q, c_q, d_q, fd_q;

  // Arithmetic, queue and credit
  nbr_t              nbr;
  logic              ar_vld;
  res_t              ar_res;
  res_t              q_data;
  logic              drop;
  logic              out_hs;
  logic [OQ_CW-1:0]  occ_r, occ_nxt;

  assign grid_wr = cfg_we && (cfg_index == CFG_GRID_SIZE);

  // Take configuration writes; hold input while lengths settle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GS_RESET;
      inv_r       <= INV_RESET;
      hold_r      <= HOLD_INIT;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GRID_SIZE: grid_size_r <= cfg_wdata[GS_W-1:0];
          CFG_INV_DX_SQ: inv_r       <= cfg_wdata;
          default:       ;
        endcase
      end
      if (grid_wr) begin
        hold_r <= HOLD_INIT;
      end else if (hold_r != '0) begin
        hold_r <= hold_r - 2'd1;
      end
    end
  end

  // Clamp the edge length into the supported range
  always_comb begin
    gs_ext = CW'(grid_size_r);
    if (gs_ext < CW'(MIN_EDGE)) begin
      n_nxt = NW'(MIN_EDGE);
    end else if (gs_ext > CW'(MAX_EDGE)) begin
      n_nxt = NW'(MAX_EDGE);
    end else begin
      n_nxt = NW'(gs_ext);
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    nm1_r   <= n_r - NW'(1);
    nm2_r   <= n_r - NW'(2);
    rw_m1_r <= RW_AW'(n_r - NW'(2));
    nn_r    <= NNW'(n_r) * NNW'(n_r);
    nnm1_r  <= nn_r - NNW'(1);
    fd_m1_r <= FD_AW'(nn_r - NNW'(1));
    pl_m1_r <= PL_AW'(nn_r - NNW'(n_r) - NNW'(1));
  end

  // Input handshake and payload
  assign in_tready = (hold_r == '0) && (occ_r < OQ_CW'(OQ_DEPTH));
  assign acc       = in_tvalid && in_tready;
  assign x_in      = in_tuser ? '0 : word_t'(in_tdata[WORD_W-1:0]);
  assign f_in      = in_tuser ? '0 : word_t'(in_tdata[2*WORD_W-1:WORD_W]);

  // Position of the point whose result this beat releases
  always_comb begin
    i_top     = (i_r == nm1_r);
    j_top     = (j_r == nm1_r);
    k_top     = (k_r == nm1_r);
    seq_last  = emit_r && i_top && j_top && k_top;
    seq_inner = emit_r &&
                (i_r != '0) && (i_r <= nm2_r) &&
                (j_r != '0) && (j_r <= nm2_r) &&
                (k_r != '0) && (k_r <= nm2_r);
    in_tag    = '{emit: emit_r, inner: seq_inner, last: seq_last};
  end

  // Count the filling plane, then walk the output position
  always_ff @(posedge clk) begin
    if (!rst_n || grid_wr) begin
      emit_r <= 1'b0;
      fill_r <= '0;
      i_r    <= '0;
      j_r    <= '0;
      k_r    <= '0;
    end else if (acc) begin
      if (!emit_r) begin
        if (fill_r == nnm1_r) begin
          fill_r <= '0;
          emit_r <= 1'b1;
        end else begin
          fill_r <= fill_r + NNW'(1);
        end
      end else if (seq_last) begin
        emit_r <= 1'b0;
        i_r    <= '0;
        j_r    <= '0;
        k_r    <= '0;
      end else if (k_top) begin
        k_r <= '0;
        if (j_top) begin
          j_r <= '0;
          i_r <= i_r + NW'(1);
        end else begin
          j_r <= j_r + NW'(1);
        end
      end else begin
        k_r <= k_r + NW'(1);
      end
    end
  end

  // f delayed by one plane
  pres7_delay #(.DEPTH(FD_DEPTH)) u_dly_f (
    .clk(clk), .rst_n(rst_n), .clr(grid_wr), .en(acc),
    .len_m1(fd_m1_r), .din(f_in), .dout(fd_q)
  );

  // u delayed by a plane less a row: neighbour at j+1
  pres7_delay #(.DEPTH(PL_DEPTH)) u_dly_a (
    .clk(clk), .rst_n(rst_n), .clr(grid_wr), .en(acc),
    .len_m1(pl_m1_r), .din(x_in), .dout(a_q)
  );

  // A row less one more: neighbour at k+1
  pres7_delay #(.DEPTH(RW_DEPTH)) u_dly_b (
    .clk(clk), .rst_n(rst_n), .clr(grid_wr), .en(v1_r),
    .len_m1(rw_m1_r), .din(a_q), .dout(b_q)
  );

  // From k-1, a row less one more: neighbour at j-1
  pres7_delay #(.DEPTH(RW_DEPTH)) u_dly_c (
    .clk(clk), .rst_n(rst_n), .clr(grid_wr), .en(v2_r),
    .len_m1(rw_m1_r), .din(p2_r), .dout(c_q)
  );

  // From j-1, a plane less a row: neighbour at i-1
  pres7_delay #(.DEPTH(PL_DEPTH)) u_dly_d (
    .clk(clk), .rst_n(rst_n), .clr(grid_wr), .en(v3_r),
    .len_m1(pl_m1_r), .din(c_q), .dout(d_q)
  );

  // Advance the plane pipeline every cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= acc;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    x1_r    <= x_in;
    tag1_r  <= in_tag;

    x2_r    <= x1_r;
    a2_r    <= a_q;
    fd2_r   <= fd_q;
    tag2_r  <= tag1_r;

    x3_r    <= x2_r;
    a3_r    <= a2_r;
    fd3_r   <= fd2_r;
    b3_r    <= b_q;
    cen3_r  <= p1_r;
    west3_r <= p2_r;
    tag3_r  <= tag2_r;

    x4_r    <= x3_r;
    a4_r    <= a3_r;
    fd4_r   <= fd3_r;
    b4_r    <= b3_r;
    cen4_r  <= cen3_r;
    west4_r <= west3_r;
    c4_r    <= c_q;
    tag4_r  <= tag3_r;
  end

  // Hold the last two k+1 words: they become centre and k-1
  always_ff @(posedge clk) begin
    if (v2_r) begin
      p1_r <= b_q;
      p2_r <= p1_r;
    end
  end

  always_comb begin
    nbr = '{c: cen4_r, im: d_q, ip: x4_r, jm: c4_r, jp: a4_r, km: west4_r, kp: b4_r};
  end

  pres7_arith u_arith (
    .clk(clk), .rst_n(rst_n),
    .in_vld(v4_r && tag4_r.emit),
    .nbr(nbr), .f_val(fd4_r),
    .inner(tag4_r.inner), .last(tag4_r.last),
    .inv(inv_r),
    .out_vld(ar_vld), .out_res(ar_res)
  );

  pres7_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .wr_en(ar_vld), .wr_data(ar_res),
    .rd_vld(out_tvalid), .rd_rdy(out_tready), .rd_data(q_data)
  );

  assign out_tdata = q_data.residual;
  assign out_tlast = q_data.last;

  // Credit: beats taken but not yet delivered or dropped
  assign drop   = v4_r && !tag4_r.emit;
  assign out_hs = out_tvalid && out_tready;

  always_comb begin
    occ_nxt = occ_r;
    if (acc)    occ_nxt = occ_nxt + OQ_CW'(1);
    if (drop)   occ_nxt = occ_nxt - OQ_CW'(1);
    if (out_hs) occ_nxt = occ_nxt - OQ_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OQ_CW'(OQ_DEPTH))
    else $error("in-flight count exceeds queue depth");

  a_occ_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == '0) |-> !out_tvalid)
    else $error("result shown with nothing in flight");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_r && hold_r == '0) |-> (i_r <= nm1_r && j_r <= nm1_r && k_r <= nm1_r))
    else $error("output position outside the grid");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && seq_last) |=> !emit_r)
    else $error("grid did not restart after its final point");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the streamed seven-point 3-D residual block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pres7_pkg::*;

  localparam int EDGE_MAX      = 64;
  localparam int WIN_LEN       = 2 * EDGE_MAX * EDGE_MAX + 1;
  localparam int FDEL_LEN      = EDGE_MAX * EDGE_MAX;
  localparam int GAP_MAX       = 11;
  localparam int SETTLE_CYCLES = 32;
  localparam int STALL_LIMIT   = 5000;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int LARGE_FILL    = 250;
  localparam int LONG_HOLD     = 400;

  typedef enum int {VAL_FULL, VAL_SMALL, VAL_CORNER} val_mode_e;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic [2*WORD_W-1:0]     in_tdata   = '0;   // u_value [31:0], f_value [63:32]
  logic                    in_tuser   = 1'b0; // pad
  logic                    out_tready = 1'b0;
  logic                    cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index  = CFG_GRID_SIZE;
  logic [INV_W-1:0]        cfg_wdata  = '0;
  wire                     in_tready;
  wire                     out_tvalid;
  wire  [WORD_W-1:0]       out_tdata;         // residual [31:0]
  wire                     out_tlast;

  // Model of the block: registers, plane buffers and grid counters
  logic [GS_W-1:0]  mdl_grid_size;
  logic [INV_W-1:0] mdl_inv;
  word_t            u_hist [WIN_LEN];
  word_t            f_hist [FDEL_LEN];
  int unsigned      pts_taken;
  int unsigned      next_out;
  res_t             residual_q [$];

  res_t        head_res;
  int          mismatches  = 0;
  int          idle_cycles = 0;
  int unsigned fed_random  = 0;
  bit          tx_burst    = 1'b0;
  bit          rx_burst    = 1'b0;
  bit          rx_hold_req = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  poisson_residual_7pt_3d_top #(
    .MAX_EDGE(EDGE_MAX)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  function automatic int unsigned edge_of(logic [GS_W-1:0] gs);
    if (gs < MIN_EDGE) return MIN_EDGE;
    if (gs > EDGE_MAX) return EDGE_MAX;
    return gs;
  endfunction

  function automatic longint sat_word(longint v);
    if (v > longint'(WORD_MAX)) return longint'(WORD_MAX);
    if (v < longint'(WORD_MIN)) return longint'(WORD_MIN);
    return v;
  endfunction

  function automatic longint u_hist_at(int unsigned pos);
    return longint'(u_hist[pos % WIN_LEN]);
  endfunction

  // Laplacian times 1/dx^2, shifted down 16, rounded half away from zero
  function automatic longint scale_laplacian(longint lap, logic [INV_W-1:0] inv);
    longint unsigned mag;
    longint unsigned hi;
    longint unsigned lo;
    longint unsigned q;
    mag = (lap < 0) ? -lap : lap;
    hi  = inv >> HALF_W;
    lo  = inv & 32'h0000_FFFF;
    q   = mag * hi + ((mag * lo + 64'h8000) >> HALF_W);
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return (lap < 0) ? sat_word(-longint'(q)) : sat_word(longint'(q));
  endfunction

  // Advance the model by one accepted beat and queue the residual it releases
  function automatic void predict_point(word_t u, word_t f, bit pad);
    int unsigned n, nn, total, t, p, c, i, j, k;
    longint      lap;
    longint      r;
    word_t       uv;
    word_t       fv;
    res_t        nxt;
    bit          grid_done;
    n         = edge_of(mdl_grid_size);
    nn        = n * n;
    total     = nn * n;
    t         = pts_taken;
    uv        = pad ? '0 : u;
    fv        = pad ? '0 : f;
    grid_done = 1'b0;
    u_hist[t % WIN_LEN] = uv;
    if (t >= nn) begin
      p = next_out;
      c = t - nn;
      i = p / nn;
      j = (p / n) % n;
      k = p % n;
      r = 0;
      if (i >= 1 && i + 2 <= n && j >= 1 && j + 2 <= n && k >= 1 && k + 2 <= n) begin
        lap = u_hist_at(c - nn) + u_hist_at(c - n) + u_hist_at(c - 1) +
              u_hist_at(c + 1) + u_hist_at(c + n) + u_hist_at(t) +
              (-6) * u_hist_at(c);
        r = sat_word(longint'(f_hist[p % FDEL_LEN]) - scale_laplacian(lap, mdl_inv));
      end
      nxt.residual = r[WORD_W-1:0];
      nxt.last     = (p + 1 == total);
      residual_q.push_back(nxt);
      next_out = p + 1;
      grid_done = (p + 1 >= total);
    end
    f_hist[t % FDEL_LEN] = fv;
    if (grid_done) begin
      pts_taken = 0;
      next_out  = 0;
    end else begin
      pts_taken = t + 1;
    end
  endfunction

  function automatic word_t rand_word(val_mode_e mode);
    int v;
    case (mode)
      VAL_SMALL: begin
        v = int'($urandom_range(0, 1 << 19)) - (1 << 18);
        return v;
      end
      VAL_CORNER: begin
        case ($urandom_range(0, 4))
          0:       return WORD_MIN;
          1:       return WORD_MAX;
          2:       return '0;
          3:       return -1;
          default: return 1;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Write one register at the next edge and mirror it in the model
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [INV_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (idx == CFG_GRID_SIZE) begin
      mdl_grid_size = data[GS_W-1:0];
      pts_taken     = 0;
      next_out      = 0;
    end else begin
      mdl_inv = data;
    end
  endtask

  // Offer one grid point after a random gap; hold until the beat is taken
  task automatic send_point(word_t u, word_t f, bit pad);
    int unsigned gap;
    bit          took;
    gap = tx_burst ? 0 : $urandom_range(0, GAP_MAX);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {f, u};
    in_tuser  <= pad;
    do begin
      @(negedge clk);
      took = in_tready;
      @(posedge clk);
    end while (!took);
    predict_point(u, f, pad);
  endtask

  // Drop valid, drain every pending residual, then let the pipeline empty
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    while (residual_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random ready gaps, plus a long hold on request
  initial begin : rx_side
    int unsigned gap;
    bit          ok;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      gap = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do begin
        @(negedge clk);
        ok = out_tvalid;
        @(posedge clk);
      end while (!ok && !rx_hold_req);
    end
  end

  // Compare each result beat with the oldest predicted residual
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (residual_q.size() == 0) begin
        report_mismatch($sformatf("residual %h arrived with none pending", out_tdata));
      end else begin
        head_res = residual_q.pop_front();
        if (out_tdata !== head_res.residual)
          report_mismatch($sformatf("residual %h, want %h", out_tdata, head_res.residual));
        if (out_tlast !== head_res.last)
          report_mismatch($sformatf("is_last %b, want %b", out_tlast, head_res.last));
      end
    end
  end

  // Abort when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Out-of-range high write acts as the largest edge: its fill phase releases nothing
  task automatic test_largest_grid();
    write_reg(CFG_GRID_SIZE, 32'd127);
    repeat (LARGE_FILL)
      send_point(rand_word(VAL_FULL), rand_word(VAL_FULL), $urandom_range(0, 15) == 0);
    wait_quiet();
  endtask

  // Smallest grid from a below-range write, full-scale values, pad masking
  task automatic test_saturation_corners();
    bit centre;
    write_reg(CFG_GRID_SIZE, 32'd2);
    write_reg(CFG_INV_DX_SQ, 32'hFFFF_FFFF);
    for (int pt = 0; pt < 27; pt++) begin
      centre = (pt == 13);
      if (pt == 0)
        send_point(rand_word(VAL_FULL), rand_word(VAL_FULL), 1'b1);
      else
        send_point(centre ? WORD_MIN : WORD_MAX, centre ? WORD_MIN : WORD_MAX, 1'b0);
    end
    repeat (9) send_point(rand_word(VAL_FULL), rand_word(VAL_FULL), 1'b1);
    wait_quiet();
  endtask

  // Abandon a grid part-way; a grid_size write must start a fresh one
  task automatic test_restart_mid_grid();
    write_reg(CFG_GRID_SIZE, 32'd4);
    write_reg(CFG_INV_DX_SQ, 32'h0000_8000);
    repeat (22) send_point(rand_word(VAL_SMALL), rand_word(VAL_SMALL), 1'b0);
    wait_quiet();
    write_reg(CFG_GRID_SIZE, 32'd4);
    for (int pt = 0; pt < 80; pt++)
      send_point(rand_word(VAL_SMALL), rand_word(VAL_SMALL), pt >= 64);
    wait_quiet();
  endtask

  // Back-to-back grids with unpadded drain beats between them
  task automatic test_grid_wrap();
    write_reg(CFG_GRID_SIZE, 32'd3);
    write_reg(CFG_INV_DX_SQ, 32'h0001_0000);
    repeat (3 * 36) send_point(rand_word(VAL_CORNER), rand_word(VAL_CORNER), 1'b0);
    wait_quiet();
  endtask

  // Receiver holds off while the sender streams: the credit must run out
  task automatic test_backpressure();
    write_reg(CFG_GRID_SIZE, 32'd5);
    write_reg(CFG_INV_DX_SQ, 32'h0001_8000);
    tx_burst    = 1'b1;
    rx_hold_req = 1'b1;
    for (int pt = 0; pt < 150; pt++)
      send_point(rand_word(VAL_SMALL), rand_word(VAL_SMALL), pt >= 125);
    tx_burst = 1'b0;
    wait_quiet();
  endtask

  // Random phases: new settings, mostly whole grids, some cut short
  task automatic test_random_grids();
    int unsigned edge_n, gs, cube, count;
    logic [INV_W-1:0] inv;
    val_mode_e   vmode;
    bit          pad;
    while (fed_random < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: edge_n = $urandom_range(3, 5);
        6, 7, 8:          edge_n = $urandom_range(6, 8);
        default:          edge_n = 10;
      endcase
      gs = (edge_n == 3 && $urandom_range(0, 1) == 1) ? $urandom_range(0, 3) : edge_n;
      case ($urandom_range(0, 7))
        0:       inv = '0;
        1:       inv = 32'hFFFF_FFFF;
        2:       inv = INV_RESET;
        3:       inv = 32'h0000_8000;
        4:       inv = 32'h0001_8000;
        5:       inv = $urandom_range(1, 16'hFFFF);
        default: inv = $urandom();
      endcase
      if ($urandom_range(0, 4) != 0) write_reg(CFG_GRID_SIZE, gs);
      if ($urandom_range(0, 3) != 0) write_reg(CFG_INV_DX_SQ, inv);
      edge_n   = edge_of(mdl_grid_size);
      cube     = edge_n * edge_n * edge_n;
      count    = $urandom_range(1, 2) * (cube + edge_n * edge_n);
      if ($urandom_range(0, 5) == 0) count = $urandom_range(1, count - 1);
      if (count > RANDOM_ITEMS - fed_random) count = RANDOM_ITEMS - fed_random;
      vmode    = val_mode_e'($urandom_range(0, 2));
      tx_burst = ($urandom_range(0, 4) == 0);
      rx_burst = ($urandom_range(0, 4) == 0);
      repeat (count) begin
        // past the last grid point only drain; pads are mostly sent there
        if (pts_taken >= cube) pad = ($urandom_range(0, 3) != 0);
        else                   pad = ($urandom_range(0, 15) == 0);
        send_point(rand_word(vmode), rand_word(vmode), pad);
        fed_random++;
      end
      tx_burst = 1'b0;
      rx_burst = 1'b0;
      wait_quiet();
    end
  endtask

  initial begin : main_seq
    mdl_grid_size = GS_RESET;
    mdl_inv       = INV_RESET;
    pts_taken     = 0;
    next_out      = 0;
    foreach (u_hist[a]) u_hist[a] = '0;
    foreach (f_hist[a]) f_hist[a] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_largest_grid();
    test_saturation_corners();
    test_restart_mid_grid();
    test_grid_wrap();
    test_backpressure();
    test_random_grids();

    if (residual_q.size() != 0)
      report_mismatch($sformatf("%0d residuals never arrived", residual_q.size()));
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
